// ===== rtl/core/sscg_pkg.sv =====
package sscg_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int NUM_FUNCS   = 64;

    localparam int ID_W   = 6;
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int FUNC_W = $clog2(NUM_FUNCS);
    localparam int DEPTH_W = 7;

    typedef enum logic [1:0] {
        KIND_ENTER  = 2'd0,
        KIND_EXIT   = 2'd1,
        KIND_EDGE   = 2'd2,
        KIND_VERIFY = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_POP_EMPTY = 3'd2,
        ST_PUSH_FULL = 3'd3,
        ST_PASS      = 3'd4,
        ST_UNKNOWN   = 3'd5,
        ST_MISSING   = 3'd6
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_EXIT   = 7'b0000100,
        S_EDGE   = 7'b0001000,
        S_VFIRST = 7'b0010000,
        S_VWALK  = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

endpackage

// ===== rtl/core/shadow_stack_call_graph_checker_top.sv =====
// Shadow stack call-graph checker: one item in flight; the next item is accepted the cycle
// after its result enters the output register.
// An enter walks the stack comparing one entry per cycle before it pushes or reports; a
// verify walks it one pair per cycle; exit and load edge read one memory word first; an
// empty exit, short verify or ignored edge goes straight to the response; a stalled output adds its stall to the item.
// Reset (synchronous, active low) empties the stack and clears known marks and row valid bits.
module shadow_stack_call_graph_checker_top
    import sscg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // func_id[5:0], edge_row[11:6], edge_col[17:12]
    input  logic [1:0]  i_s_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // newer_id[5:0], older_id[11:6], depth[18:12]
    output logic [2:0]  o_m_axis_tuser    // status[2:0]
);

    t_state r_state, n_state;

    logic [ID_W-1:0]  r_fid, n_fid;
    logic [ID_W-1:0]  r_row, n_row;
    logic [ID_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_left, n_left;
    logic [NUM_FUNCS-1:0] r_known, n_known;
    logic [NUM_FUNCS-1:0] r_row_vld, n_row_vld;
    t_status          r_status, n_status;
    logic [ID_W-1:0]  r_newer, n_newer;
    logic [ID_W-1:0]  r_older, n_older;
    logic [ID_W-1:0]  r_pair_new, n_pair_new;

    logic             r_out_valid, n_out_valid;
    logic [23:0]      r_out_data, n_out_data;
    logic [2:0]       r_out_user, n_out_user;

    // stack memory
    logic [ID_W-1:0]  stack_mem [STACK_DEPTH];
    logic             stk_rd_en, stk_wr_en;
    logic [SP_W-1:0]  stk_rd_addr, stk_wr_addr;
    logic [ID_W-1:0]  stk_wr_data;
    logic [ID_W-1:0]  r_rd_data;
    logic             r_rd_pend;

    // allowed-call matrix memory, one row per callee, indexed by the newer stack entry
    logic [NUM_FUNCS-1:0] mat_mem [NUM_FUNCS];
    logic                 mat_rd_en, mat_wr_en;
    logic [FUNC_W-1:0]    mat_rd_addr, mat_wr_addr;
    logic [NUM_FUNCS-1:0] mat_wr_data;
    logic [NUM_FUNCS-1:0] r_mrow;
    logic                 r_mrow_ok;
    logic [NUM_FUNCS-1:0] mrow_eff;

    logic [ID_W-1:0]  in_fid, in_row, in_col;
    t_kind            in_kind;
    logic             in_accept;
    logic             row_out_of_range, col_out_of_range;
    logic             newer_known, older_known;
    logic [NUM_FUNCS-1:0] col_bit;

    assign in_fid  = i_s_axis_tdata[5:0];
    assign in_row  = i_s_axis_tdata[11:6];
    assign in_col  = i_s_axis_tdata[17:12];
    assign in_kind = t_kind'(i_s_axis_tuser);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign mrow_eff = r_mrow_ok ? r_mrow : '0;
    assign col_bit  = {{(NUM_FUNCS-1){1'b0}}, 1'b1} << r_col[FUNC_W-1:0];

    assign row_out_of_range = ({1'b0, in_row} >= (ID_W+1)'(NUM_FUNCS));
    assign col_out_of_range = ({1'b0, in_col} >= (ID_W+1)'(NUM_FUNCS));

    // pair check during verify: newer is held, older is fresh from the stack memory
    assign newer_known = ({1'b0, r_pair_new} < (ID_W+1)'(NUM_FUNCS))
                         && r_known[r_pair_new[FUNC_W-1:0]];
    assign older_known = ({1'b0, r_rd_data} < (ID_W+1)'(NUM_FUNCS))
                         && r_known[r_rd_data[FUNC_W-1:0]];

    always_comb begin
        n_state     = r_state;
        n_fid       = r_fid;
        n_row       = r_row;
        n_col       = r_col;
        n_count     = r_count;
        n_idx       = r_idx;
        n_left      = r_left;
        n_known     = r_known;
        n_row_vld   = r_row_vld;
        n_status    = r_status;
        n_newer     = r_newer;
        n_older     = r_older;
        n_pair_new  = r_pair_new;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        stk_rd_en   = 1'b0;
        stk_rd_addr = '0;
        stk_wr_en   = 1'b0;
        stk_wr_addr = r_count[SP_W-1:0];
        stk_wr_data = r_fid;
        mat_rd_en   = 1'b0;
        mat_rd_addr = '0;
        mat_wr_en   = 1'b0;
        mat_wr_addr = r_row[FUNC_W-1:0];
        mat_wr_data = mrow_eff | col_bit;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_fid    = in_fid;
                    n_row    = in_row;
                    n_col    = in_col;
                    n_status = ST_DONE;
                    n_newer  = '0;
                    n_older  = '0;
                    case (in_kind)
                        KIND_ENTER: begin
                            n_idx   = '0;
                            n_state = S_SEARCH;
                        end
                        KIND_EXIT: begin
                            if (r_count == '0) begin
                                n_status = ST_POP_EMPTY;
                                n_state  = S_RESP;
                            end else begin
                                stk_rd_en   = 1'b1;
                                stk_rd_addr = SP_W'(r_count - CNT_W'(1));
                                n_state     = S_EXIT;
                            end
                        end
                        KIND_EDGE: begin
                            if (row_out_of_range || col_out_of_range) begin
                                n_status = ST_IGNORED;
                                n_state  = S_RESP;
                            end else begin
                                mat_rd_en   = 1'b1;
                                mat_rd_addr = in_row[FUNC_W-1:0];
                                n_state     = S_EDGE;
                            end
                        end
                        KIND_VERIFY: begin
                            if (r_count < CNT_W'(2)) begin
                                n_status = ST_PASS;
                                n_state  = S_RESP;
                            end else begin
                                stk_rd_en   = 1'b1;
                                stk_rd_addr = SP_W'(r_count - CNT_W'(1));
                                n_idx       = r_count - CNT_W'(2);
                                n_left      = r_count - CNT_W'(1);
                                n_state     = S_VFIRST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                // compare the entry read last cycle while the next one is fetched
                if (r_rd_pend && (r_rd_data == r_fid)) begin
                    n_status = ST_IGNORED;
                    n_state  = S_RESP;
                end else if (r_idx < r_count) begin
                    stk_rd_en   = 1'b1;
                    stk_rd_addr = r_idx[SP_W-1:0];
                    n_idx       = r_idx + CNT_W'(1);
                end else if (r_count >= CNT_W'(STACK_DEPTH)) begin
                    n_status = ST_PUSH_FULL;
                    n_state  = S_RESP;
                end else begin
                    stk_wr_en = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                    n_state   = S_RESP;
                end
            end

            S_EXIT: begin
                if (r_rd_data == r_fid) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_IGNORED;
                end
                n_state = S_RESP;
            end

            S_EDGE: begin
                mat_wr_en = 1'b1;
                n_row_vld[r_row[FUNC_W-1:0]] = 1'b1;
                n_known[r_row[FUNC_W-1:0]]   = 1'b1;
                n_known[r_col[FUNC_W-1:0]]   = 1'b1;
                n_state = S_RESP;
            end

            S_VFIRST: begin
                // hold the top entry as newer and fetch its matrix row
                n_pair_new  = r_rd_data;
                mat_rd_en   = 1'b1;
                mat_rd_addr = r_rd_data[FUNC_W-1:0];
                stk_rd_en   = 1'b1;
                stk_rd_addr = r_idx[SP_W-1:0];
                n_idx       = r_idx - CNT_W'(1);
                n_state     = S_VWALK;
            end

            S_VWALK: begin
                if (!newer_known || !older_known) begin
                    n_status = ST_UNKNOWN;
                    n_newer  = r_pair_new;
                    n_older  = r_rd_data;
                    n_state  = S_RESP;
                end else if (!mrow_eff[r_rd_data[FUNC_W-1:0]]) begin
                    n_status = ST_MISSING;
                    n_newer  = r_pair_new;
                    n_older  = r_rd_data;
                    n_state  = S_RESP;
                end else if (r_left == CNT_W'(1)) begin
                    n_status = ST_PASS;
                    n_state  = S_RESP;
                end else begin
                    // advance one pair: older becomes the next newer
                    n_left      = r_left - CNT_W'(1);
                    n_pair_new  = r_rd_data;
                    mat_rd_en   = 1'b1;
                    mat_rd_addr = r_rd_data[FUNC_W-1:0];
                    stk_rd_en   = 1'b1;
                    stk_rd_addr = r_idx[SP_W-1:0];
                    n_idx       = r_idx - CNT_W'(1);
                end
            end

            S_RESP: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_status;
                    n_out_data  = {5'd0, DEPTH_W'(r_count), r_older, r_newer};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_wr_en) begin
            stack_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en) begin
            r_rd_data <= stack_mem[stk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mat_wr_en) begin
            mat_mem[mat_wr_addr] <= mat_wr_data;
        end
        if (mat_rd_en) begin
            r_mrow    <= mat_mem[mat_rd_addr];
            r_mrow_ok <= r_row_vld[mat_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_known     <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_known     <= n_known;
            r_row_vld   <= n_row_vld;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= stk_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fid      <= n_fid;
        r_row      <= n_row;
        r_col      <= n_col;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_status   <= n_status;
        r_newer    <= n_newer;
        r_older    <= n_older;
        r_pair_new <= n_pair_new;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule
